### design/cds_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: shared definitions
// Types, calendar constants and month tables used by the conversion stages.
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam logic [11:0] FIRST_YEAR    = 12'd2000;
   localparam logic [11:0] LAST_YEAR     = 12'd2099;
   localparam logic [3:0]  FEBRUARY      = 4'd2;
   localparam logic [3:0]  MONTHS        = 4'd12;
   localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
   localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [4:0]  LEAP_FEB_DAYS = 5'd29;
   localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] WEEKDAY_BIAS  = 17'd6;

   // Reciprocal of seven, exact for dividends below 2^19 / 5.
   localparam int          RECIP_SHIFT   = 19;
   localparam logic [16:0] RECIP_SEVEN   = 17'd74899;
   localparam logic [16:0] DAYS_PER_WEEK = 17'd7;

   // Days since the epoch, time of day and range check of one request.
   typedef struct packed {
      logic        ok;
      logic [15:0] days;
      logic [16:0] tod;
   } cds_day_type;

   // One finished result.
   typedef struct packed {
      logic        ok;
      logic [15:0] days;
      logic [31:0] secs;
      logic [2:0]  weekday;
   } cds_res_type;

   // Length of a month in a common year.
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // Days before the first of a month in a common year.
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] d;
      unique case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

### design/calendar_date_to_seconds.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds
// Converts a broken-down date and time into days and seconds since 2000.
// ----------------------------------------------------------------------------
// The block turns a date and time from the years 2000 to 2099 into the number
// of days and of seconds since 2000-01-01 00:00:00 and the day of the week,
// with 0 for Sunday. It takes one request in every clock cycle while the
// result side keeps taking, and passes each through two registered stages:
// the first checks the fields and forms the day count and the time of day,
// the second scales the day count to seconds and reduces it modulo seven.
// Both stages advance together whenever the result register is empty or
// being emptied, so a new request is taken in the same cycle in which a
// waiting result leaves. A request with any field out of range, including a
// day beyond the length of its month, yields a result with the validity flag
// low and all numeric fields at zero.
// ----------------------------------------------------------------------------
module calendar_date_to_seconds import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [15:0] rsp_day_count,
   output logic [31:0] rsp_epoch_seconds,
   output logic [2:0]  rsp_weekday
);

   logic        day_valid;
   cds_day_type day_data;
   logic        res_valid;
   cds_res_type res_data;
   logic        res_take;
   logic        day_take;

   // The result register may load when it is empty or its result is leaving
   // this cycle; the day stage may load when its own contents move on.
   assign res_take  = !res_valid || rsp_ready;
   assign day_take  = !day_valid || res_take;
   assign req_ready = day_take;

   cds_day_stage u_day (
      .clock     (clock),
      .reset     (reset),
      .take      (day_take),
      .in_valid  (req_valid),
      .year      (req_year),
      .month     (req_month),
      .day       (req_day),
      .hour      (req_hour),
      .minute    (req_minute),
      .second    (req_second),
      .out_valid (day_valid),
      .out_data  (day_data)
   );

   cds_sec_stage u_sec (
      .clock     (clock),
      .reset     (reset),
      .take      (res_take),
      .in_valid  (day_valid),
      .in_data   (day_data),
      .out_valid (res_valid),
      .out_data  (res_data)
   );

   assign rsp_valid         = res_valid;
   assign rsp_valid_res     = res_data.ok;
   assign rsp_day_count     = res_data.days;
   assign rsp_epoch_seconds = res_data.secs;
   assign rsp_weekday       = res_data.weekday;

endmodule

### design/cds_day_stage.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: day stage
// Checks the fields of a request and registers its day count and time of day.
// ----------------------------------------------------------------------------
module cds_day_stage import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic        in_valid,
   input  logic [11:0] year,
   input  logic [3:0]  month,
   input  logic [4:0]  day,
   input  logic [4:0]  hour,
   input  logic [5:0]  minute,
   input  logic [5:0]  second,
   output logic        out_valid,
   output cds_day_type out_data
);

   logic        valid_ff, valid_in;
   cds_day_type data_ff, data_in;

   logic        leap;
   logic        field_ok;
   logic [4:0]  mlen;
   logic [11:0] yo_full;
   logic [6:0]  yo;
   logic [15:0] days;
   logic [16:0] tod;

   always_comb begin
      leap     = (year[1:0] == 2'b00);
      mlen     = (month == FEBRUARY && leap) ? LEAP_FEB_DAYS : month_len(month);
      field_ok = (year >= FIRST_YEAR) && (year <= LAST_YEAR) &&
                 (month >= 4'd1) && (month <= MONTHS) &&
                 (hour < HOURS_PER_DAY) && (minute < MINS_PER_HOUR) &&
                 (second < SECS_PER_MIN) &&
                 (day >= 5'd1) && (day <= mlen);
      yo_full  = year - FIRST_YEAR;
      yo       = yo_full[6:0];
      // Leap days before this year: one for every fourth year, counting 2000.
      days     = 16'(yo) * DAYS_PER_YEAR + 16'((8'(yo) + 8'd3) >> 2) +
                 16'(days_before(month)) +
                 16'((month > FEBRUARY && leap) ? 1'b1 : 1'b0) +
                 16'(day - 5'd1);
      tod      = 17'(hour) * SECS_PER_HOUR + 17'(minute) * 17'(SECS_PER_MIN) +
                 17'(second);

      data_in.ok   = field_ok;
      data_in.days = field_ok ? days : 16'd0;
      data_in.tod  = field_ok ? tod  : 17'd0;
      valid_in     = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/cds_sec_stage.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: seconds stage
// Scales the day count to seconds, derives the weekday and holds the result.
// ----------------------------------------------------------------------------
module cds_sec_stage import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic        in_valid,
   input  cds_day_type in_data,
   output logic        out_valid,
   output cds_res_type out_data
);

   logic        valid_ff, valid_in;
   cds_res_type data_ff, data_in;

   logic [16:0] biased;
   logic [33:0] prod;
   logic [14:0] quot;
   logic [16:0] rem;

   always_comb begin
      // The weekday is (days + 6) mod 7; 2000-01-01 was a Saturday.
      biased = 17'(in_data.days) + WEEKDAY_BIAS;
      prod   = 34'(biased) * 34'(RECIP_SEVEN);
      quot   = prod[RECIP_SHIFT +: 15];
      rem    = biased - 17'(quot) * DAYS_PER_WEEK;

      data_in.ok      = in_data.ok;
      data_in.days    = in_data.days;
      data_in.secs    = 32'(in_data.days) * SECS_PER_DAY + 32'(in_data.tod);
      data_in.weekday = in_data.ok ? rem[2:0] : 3'd0;
      valid_in        = take ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/cds_checker.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: port checker
// Watches the top level's ports for consistency of the results over time.
// ----------------------------------------------------------------------------
module cds_port_checker import cds_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_valid_res,
   input logic [15:0] rsp_day_count,
   input logic [31:0] rsp_epoch_seconds,
   input logic [2:0]  rsp_weekday
);

   // No result can be offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_res) &&
      $stable(rsp_day_count) && $stable(rsp_epoch_seconds) && $stable(rsp_weekday))
      else $error("stalled result changed");

   // A rejected request carries all-zero numeric fields.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
      rsp_day_count == 16'd0 && rsp_epoch_seconds == 32'd0 && rsp_weekday == 3'd0)
      else $error("invalid result with nonzero fields");

   // The seconds lie within the day that the day count names.
   a_same_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
      rsp_epoch_seconds >= 32'(rsp_day_count) * SECS_PER_DAY &&
      rsp_epoch_seconds - 32'(rsp_day_count) * SECS_PER_DAY < SECS_PER_DAY)
      else $error("seconds disagree with day count");

   // Day count and weekday stay inside the calendar.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_day_count <= 16'd36524 && rsp_weekday <= 3'd6)
      else $error("day count or weekday out of range");

endmodule

bind calendar_date_to_seconds cds_port_checker u_cds_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_valid_res     (rsp_valid_res),
   .rsp_day_count     (rsp_day_count),
   .rsp_epoch_seconds (rsp_epoch_seconds),
   .rsp_weekday       (rsp_weekday)
);

### tb/cds_checker.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: result checker
// Watches both channels, works out the expected days, seconds and weekday for
// every accepted request and compares each delivered result with the oldest
// one still waiting.
// ----------------------------------------------------------------------------
module cds_checker import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_valid_res,
   input  logic [15:0] rsp_day_count,
   input  logic [31:0] rsp_epoch_seconds,
   input  logic [2:0]  rsp_weekday,
   output int          error_count,
   output int          pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DAYS_IN_YEAR    = 365;
   localparam int unsigned SECONDS_IN_DAY  = 86400;
   localparam int unsigned SECONDS_IN_HOUR = 3600;
   localparam int unsigned SECONDS_IN_MIN  = 60;
   localparam int unsigned SATURDAY        = 6;
   localparam int unsigned REPORT_LIMIT    = 10;

   cds_res_type expected_results[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic int unsigned days_in_month(input int unsigned mo, input bit leap);
      int unsigned len;
      case (mo)
         4, 6, 9, 11: len = 30;
         2:           len = leap ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // Every out-of-range field, a day past the end of its month included,
   // gives a result that is all zero.
   function automatic cds_res_type civil_to_epoch(input logic [11:0] yr,
                                                  input logic [3:0]  mo,
                                                  input logic [4:0]  dy,
                                                  input logic [4:0]  hr,
                                                  input logic [5:0]  mi,
                                                  input logic [5:0]  se);
      cds_res_type      res;
      bit               leap;
      int unsigned      span;
      int unsigned      days;
      longint unsigned  secs;
      res  = '0;
      leap = (yr[1:0] == 2'b00);
      if (yr < FIRST_YEAR || yr > LAST_YEAR || mo < 1 || mo > MONTHS ||
          hr >= HOURS_PER_DAY || mi >= MINS_PER_HOUR || se >= SECS_PER_MIN)
         return res;
      if (dy < 1 || dy > days_in_month(mo, leap))
         return res;
      span = yr - FIRST_YEAR;
      days = span * DAYS_IN_YEAR + (span + 3) / 4;
      for (int m = 1; m < mo; m++)
         days += days_in_month(m, leap);
      days += dy - 1;
      secs = longint'(days) * SECONDS_IN_DAY + longint'(hr) * SECONDS_IN_HOUR +
             longint'(mi) * SECONDS_IN_MIN + longint'(se);
      res.ok      = 1'b1;
      res.days    = days[15:0];
      res.secs    = secs[31:0];
      res.weekday = 3'((days + SATURDAY) % 7);
      return res;
   endfunction

   always @(posedge clock) begin
      cds_res_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(civil_to_epoch(req_year, req_month, req_day,
                                                      req_hour, req_minute, req_second));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%t: unexpected result ok=%0d days=%0d secs=%0d weekday=%0d",
                           $realtime, rsp_valid_res, rsp_day_count, rsp_epoch_seconds,
                           rsp_weekday);
            end else begin
               want = expected_results.pop_front();
               if (rsp_valid_res !== want.ok || rsp_day_count !== want.days ||
                   rsp_epoch_seconds !== want.secs || rsp_weekday !== want.weekday) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display({"%t: mismatch, expected ok=%0d days=%0d secs=%0d weekday=%0d,",
                               " got ok=%0d days=%0d secs=%0d weekday=%0d"},
                              $realtime, want.ok, want.days, want.secs, want.weekday,
                              rsp_valid_res, rsp_day_count, rsp_epoch_seconds, rsp_weekday);
               end
            end
         end
         pending_count = expected_results.size();
      end
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Calendar date to seconds: testbench top
// Drives requests into the converter, lets the receiver stall at random and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb import cds_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // A stretch with no request or result accepted at all, longer than any
   // correct run can produce, is taken as a hang.
   localparam int WATCHDOG_LIMIT = 5000;
   // Length of the deliberate receiver hold-off, long enough for the block
   // to fill up and push back on its input.
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 220;
   localparam int TAIL_CYCLES    = 10;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [11:0] req_year          = '0;
   logic [3:0]  req_month         = '0;
   logic [4:0]  req_day           = '0;
   logic [4:0]  req_hour          = '0;
   logic [5:0]  req_minute        = '0;
   logic [5:0]  req_second        = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_valid_res;
   logic [15:0] rsp_day_count;
   logic [31:0] rsp_epoch_seconds;
   logic [2:0]  rsp_weekday;

   int error_count;
   int pending_count;
   int send_idle_pct     = 0;
   int recv_stall_pct    = 0;
   int idle_cycles       = 0;
   bit hold_off_request  = 1'b0;

   // The clock runs with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   calendar_date_to_seconds u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_day_count     (rsp_day_count),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_weekday       (rsp_weekday)
   );

   cds_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_day_count     (rsp_day_count),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_weekday       (rsp_weekday),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   // Offers one request after a random number of idle cycles and returns at
   // the edge on which it is accepted. The valid stays high from one request
   // to the next whenever no idle cycle falls between them, so it is never
   // lowered and raised again within a single time step.
   task automatic send_request(input logic [11:0] yr, input logic [3:0] mo,
                               input logic [4:0] dy, input logic [4:0] hr,
                               input logic [5:0] mi, input logic [5:0] se);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_year   <= yr;
      req_month  <= mo;
      req_day    <= dy;
      req_hour   <= hr;
      req_minute <= mi;
      req_second <= se;
      do @(posedge clock); while (!req_ready);
   endtask

   // Most random requests draw each field from its valid range (the day from 1
   // to 31 in every month), since only those exercise the day and second
   // arithmetic. The rest sit on the edges of each field's valid range or are pure noise across every bit.
   task automatic send_random_date();
      int          kind;
      logic [11:0] yr;
      logic [3:0]  mo;
      logic [4:0]  dy;
      logic [4:0]  hr;
      logic [5:0]  mi;
      logic [5:0]  se;
      kind = $urandom_range(99);
      if (kind < 70) begin
         yr = 12'($urandom_range(LAST_YEAR, FIRST_YEAR));
         mo = 4'($urandom_range(12, 1));
         dy = 5'($urandom_range(31, 1));
         hr = 5'($urandom_range(23, 0));
         mi = 6'($urandom_range(59, 0));
         se = 6'($urandom_range(59, 0));
      end else if (kind < 85) begin
         yr = $urandom_range(1) ? 12'($urandom_range(2001, 1999))
                                : 12'($urandom_range(2100, 2098));
         mo = $urandom_range(1) ? 4'($urandom_range(2, 0)) : 4'($urandom_range(13, 11));
         dy = $urandom_range(1) ? 5'($urandom_range(1, 0)) : 5'($urandom_range(31, 28));
         hr = $urandom_range(1) ? 5'($urandom_range(1, 0)) : 5'($urandom_range(24, 22));
         mi = $urandom_range(1) ? 6'($urandom_range(1, 0)) : 6'($urandom_range(60, 58));
         se = $urandom_range(1) ? 6'($urandom_range(1, 0)) : 6'($urandom_range(60, 58));
      end else begin
         yr = 12'($urandom);
         mo = 4'($urandom);
         dy = 5'($urandom);
         hr = 5'($urandom);
         mi = 6'($urandom);
         se = 6'($urandom);
      end
      send_request(yr, mo, dy, hr, mi, se);
   endtask

   // The sender holds back until the checker has seen every expected result.
   // At least one edge passes first, so a request accepted on the current
   // edge is already counted.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // The receiver stalls at random, except for one long hold-off that is
   // timed here, in its own process, while the sender keeps offering.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // The watchdog counts cycles in which neither a request nor a result is
   // accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: the first and last instants of the century, leap
      // and common Februaries, the day after a leap day, months of thirty
      // days, and every field just outside its range or at its maximum.
      send_request(12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
      send_request(12'd2000, 4'd2,  5'd29, 5'd12, 6'd30, 6'd30);
      send_request(12'd2001, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0);
      send_request(12'd2004, 4'd2,  5'd29, 5'd1,  6'd2,  6'd3);
      send_request(12'd2099, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59);
      send_request(12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2001, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2000, 4'd4,  5'd30, 5'd16, 6'd32, 6'd16);
      send_request(12'd2000, 4'd4,  5'd31, 5'd0,  6'd0,  6'd0);
      send_request(12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
      send_request(12'd2100, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd0,    4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd4095, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2050, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2050, 4'd13, 5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2050, 4'd15, 5'd1,  5'd0,  6'd0,  6'd0);
      send_request(12'd2050, 4'd6,  5'd0,  5'd0,  6'd0,  6'd0);
      send_request(12'd2050, 4'd6,  5'd15, 5'd24, 6'd0,  6'd0);
      send_request(12'd2050, 4'd6,  5'd15, 5'd31, 6'd0,  6'd0);
      send_request(12'd2050, 4'd6,  5'd15, 5'd0,  6'd60, 6'd0);
      send_request(12'd2050, 4'd6,  5'd15, 5'd0,  6'd63, 6'd0);
      send_request(12'd2050, 4'd6,  5'd15, 5'd0,  6'd0,  6'd60);
      send_request(12'd2050, 4'd6,  5'd15, 5'd0,  6'd0,  6'd63);
      send_request(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
      wait_for_drain();

      // Random phases: no idling, a lazy sender, a stalling receiver, then
      // both. The first phase opens with the long receiver hold-off.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         if (phase == 0)
            hold_off_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_date();
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
